// ----- hw/rtl/apuf_pkg.sv -----
// ----------------------------------------------------------------------------
// apuf_pkg
// shared types and constants of the arbiter puf delay model
// ----------------------------------------------------------------------------
`default_nettype none

package apuf_pkg;

    localparam int STAGES_DEF  = 64;
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int DELAY_W     = 16;
    localparam int DIFF_W      = 22;
    localparam int CHAL_W      = 64;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    localparam logic TABLE_ZERO = 1'b0;
    localparam logic TABLE_ONE  = 1'b1;

    typedef struct packed {
        logic clear;
        logic step;
        logic path_bit;
    } t_acc_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/apuf_ram.sv -----
// ----------------------------------------------------------------------------
// apuf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module apuf_ram #(
    parameter int   WIDTH = 16,
    parameter int   DEPTH = 64,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/apuf_acc.sv -----
// ----------------------------------------------------------------------------
// apuf_acc
// running delay difference, one stage per step
// ----------------------------------------------------------------------------
`default_nettype none

module apuf_acc (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire apuf_pkg::t_acc_ctl                i_ctl,
    input  wire logic signed [apuf_pkg::DELAY_W-1:0] i_zero_delay,
    input  wire logic signed [apuf_pkg::DELAY_W-1:0] i_one_delay,
    output logic signed      [apuf_pkg::DIFF_W-1:0]  o_diff_next
);

    localparam int EXT_W = apuf_pkg::DIFF_W - apuf_pkg::DELAY_W;

    logic signed [apuf_pkg::DIFF_W-1:0] r_diff;
    logic signed [apuf_pkg::DIFF_W-1:0] zero_ext;
    logic signed [apuf_pkg::DIFF_W-1:0] one_ext;
    logic signed [apuf_pkg::DIFF_W-1:0] n_diff;

    assign zero_ext = {{EXT_W{i_zero_delay[apuf_pkg::DELAY_W-1]}}, i_zero_delay};
    assign one_ext  = {{EXT_W{i_one_delay[apuf_pkg::DELAY_W-1]}}, i_one_delay};

    // crossed path flips the sign of the difference
    always_comb begin
        if (i_ctl.path_bit) begin
            n_diff = one_ext - r_diff;
        end else begin
            n_diff = r_diff + zero_ext;
        end
    end

    assign o_diff_next = n_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_diff <= '0;
        end else if (i_ctl.step) begin
            r_diff <= n_diff;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/arbiter_puf_delay_model.sv -----
// ----------------------------------------------------------------------------
// arbiter_puf_delay_model
// additive delay model of an arbiter puf with two stage delay tables
//
//   channel   signals                                        transfer when
//   input     start, busy, i_func, i_table_select,           start && !busy
//             i_entry_index, i_delay_value, i_challenge
//   result    o_valid, o_response, o_delay_difference        o_valid
//
// a write gives no result
// an evaluation reads one table entry per stage from the two delay rams, does
// the last add in the flush state and loads the sum into the result register
// the result strobe is high for one cycle, busy is already low in that cycle
// synchronous active-low reset clears control state, ram contents stay
// ----------------------------------------------------------------------------
`default_nettype none

module arbiter_puf_delay_model #(
    parameter int STAGES = apuf_pkg::STAGES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_func,
    input  wire logic                                i_table_select,
    input  wire logic        [apuf_pkg::ADDR_W-1:0]  i_entry_index,
    input  wire logic signed [apuf_pkg::DELAY_W-1:0] i_delay_value,
    input  wire logic        [apuf_pkg::CHAL_W-1:0]  i_challenge,
    output logic                                     o_valid,
    output logic                                     o_response,
    output logic signed      [apuf_pkg::DIFF_W-1:0]  o_delay_difference
);

    localparam int CNT_W = $clog2(STAGES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH
    } t_state;

    t_state                             r_state;
    logic [CNT_W-1:0]                   r_cnt;
    logic [STAGES-1:0]                  r_chal;
    logic                               r_rd_vld;
    logic                               r_bit_d;

    logic                               accept;
    logic                               we_zero;
    logic                               we_one;
    logic [apuf_pkg::ADDR_W-1:0]        raddr;
    logic signed [apuf_pkg::DELAY_W-1:0] zero_rdata;
    logic signed [apuf_pkg::DELAY_W-1:0] one_rdata;
    logic signed [apuf_pkg::DIFF_W-1:0]  diff_next;
    apuf_pkg::t_acc_ctl                 acc_ctl;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign we_zero = accept && (i_func == apuf_pkg::FUNC_WRITE)
                     && (i_table_select == apuf_pkg::TABLE_ZERO);
    assign we_one  = accept && (i_func == apuf_pkg::FUNC_WRITE)
                     && (i_table_select == apuf_pkg::TABLE_ONE);
    assign raddr   = apuf_pkg::ADDR_W'(r_cnt);

    assign acc_ctl.clear    = accept && (i_func == apuf_pkg::FUNC_EVAL);
    assign acc_ctl.step     = r_rd_vld;
    assign acc_ctl.path_bit = r_bit_d;

    apuf_ram #(
        .WIDTH (apuf_pkg::DELAY_W),
        .DEPTH (apuf_pkg::TABLE_DEPTH)
    ) u_zero_ram (
        .i_clk   (i_clk),
        .i_we    (we_zero),
        .i_waddr (i_entry_index),
        .i_wdata (i_delay_value),
        .i_raddr (raddr),
        .o_rdata (zero_rdata)
    );

    apuf_ram #(
        .WIDTH (apuf_pkg::DELAY_W),
        .DEPTH (apuf_pkg::TABLE_DEPTH)
    ) u_one_ram (
        .i_clk   (i_clk),
        .i_we    (we_one),
        .i_waddr (i_entry_index),
        .i_wdata (i_delay_value),
        .i_raddr (raddr),
        .o_rdata (one_rdata)
    );

    apuf_acc u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (acc_ctl),
        .i_zero_delay (zero_rdata),
        .i_one_delay  (one_rdata),
        .o_diff_next  (diff_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_rd_vld <= (r_state == S_RUN);
            r_bit_d  <= r_chal[0];
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_func == apuf_pkg::FUNC_EVAL)) begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                        r_chal  <= i_challenge[STAGES-1:0];
                    end
                end
                S_RUN: begin
                    r_chal <= r_chal >> 1;
                    if (r_cnt == CNT_W'(STAGES - 1)) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FLUSH: begin
                    r_state            <= S_IDLE;
                    o_valid            <= 1'b1;
                    o_response         <= !diff_next[apuf_pkg::DIFF_W-1]
                                          && (diff_next != '0);
                    o_delay_difference <= diff_next;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_valid_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_FLUSH))
        else $error("result strobe without a finished walk");

    a_stage_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt != CNT_W'(STAGES - 1))
        |=> (r_state == S_RUN && r_cnt == $past(r_cnt) + 1'b1))
        else $error("stage counter skipped or left the walk early");

    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == apuf_pkg::FUNC_EVAL) |=> (r_state == S_RUN && r_cnt == '0))
        else $error("evaluation transfer did not start the walk at stage zero");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN || r_state == S_FLUSH) |-> !(we_zero || we_one))
        else $error("table write during an evaluation");

    a_response_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_response == (!o_delay_difference[apuf_pkg::DIFF_W-1]
                                    && o_delay_difference != '0)))
        else $error("response does not match the sign of the difference");
`endif

endmodule

`default_nettype wire
